// ===== hdl/exyz_pkg.sv =====
`timescale 1ns / 1ps

package exyz_pkg;

  // fixed field widths
  localparam int COORD_WIDTH   = 32;
  // working width of the rotated coordinates (vector norm grows by up to sqrt 3)
  localparam int INT_WIDTH     = COORD_WIDTH + 2;
  localparam int ANGLE_WIDTH   = 9;
  localparam int CFG_IDX_WIDTH = 2;
  // quarter-wave sine table covers 0..90 degrees
  localparam int SIN_ENTRIES   = 91;
  localparam int SIN_IDX_WIDTH = 7;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_Z = 2'd2;

  // pi in Q52
  localparam logic [63:0] PI_Q52 = 64'h0032_43F6_A888_5A31;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;
    logic                          last_in;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
    logic                          last_out;
  } out_t;

  // vertex inside the pipe, at working width
  typedef struct packed {
    logic signed [INT_WIDTH-1:0] x;
    logic signed [INT_WIDTH-1:0] y;
    logic signed [INT_WIDTH-1:0] z;
    logic                        last;
  } vec_t;

  // quarter-wave lookup: table index and sign
  typedef struct packed {
    logic [SIN_IDX_WIDTH-1:0] idx;
    logic                     neg;
  } fold_t;

  // reduce an angle below 720 into 0..359
  function automatic logic [ANGLE_WIDTH-1:0] norm_angle(input logic [ANGLE_WIDTH:0] a);
    logic [ANGLE_WIDTH:0] r;
    if (a >= 10'd360) begin
      r = a - 10'd360;
    end else begin
      r = a;
    end
    return r[ANGLE_WIDTH-1:0];
  endfunction

  // map 0..359 onto the quarter wave
  function automatic fold_t fold_angle(input logic [ANGLE_WIDTH-1:0] a);
    fold_t f;
    logic [ANGLE_WIDTH-1:0] d;
    if (a <= 9'd90) begin
      d     = a;
      f.neg = 1'b0;
    end else if (a <= 9'd180) begin
      d     = 9'd180 - a;
      f.neg = 1'b0;
    end else if (a <= 9'd270) begin
      d     = a - 9'd180;
      f.neg = 1'b1;
    end else begin
      d     = 9'd360 - a;
      f.neg = 1'b1;
    end
    f.idx = d[SIN_IDX_WIDTH-1:0];
    return f;
  endfunction

  // sin(k degrees) as unsigned Q30 from a truncated taylor series, for table elaboration
  function automatic logic [63:0] sin_q30(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] acc;
    x   = ((64'(k) * PI_Q52) / 64'd180 + (64'd1 << 21)) >> 22;
    x2  = (x * x + (64'd1 << 29)) >> 30;
    t   = x;
    acc = x;
    for (int n = 1; n <= 8; n++) begin
      t = (t * x2 + (64'd1 << 29)) >> 30;
      case (n)
        1:       t = (t + 64'd3) / 64'd6;
        2:       t = (t + 64'd10) / 64'd20;
        3:       t = (t + 64'd21) / 64'd42;
        4:       t = (t + 64'd36) / 64'd72;
        5:       t = (t + 64'd55) / 64'd110;
        6:       t = (t + 64'd78) / 64'd156;
        7:       t = (t + 64'd105) / 64'd210;
        default: t = (t + 64'd136) / 64'd272;
      endcase
      if ((n % 2) == 1) begin
        acc = (t > acc) ? 64'd0 : acc - t;
      end else begin
        acc = acc + t;
      end
    end
    return acc;
  endfunction

endpackage

// ===== hdl/exyz_trig.sv =====
`timescale 1ns / 1ps

module exyz_trig #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_wen,
  input  logic [exyz_pkg::CFG_IDX_WIDTH-1:0]           cfg_index,
  input  logic [exyz_pkg::ANGLE_WIDTH-1:0]             cfg_wdata,
  output logic signed [TRIG_FRAC_BITS+1:0]             sin_v [3],
  output logic signed [TRIG_FRAC_BITS+1:0]             cos_v [3]
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam logic signed [TW-1:0] ONE = TW'(1) << TRIG_FRAC_BITS;

  logic [TRIG_FRAC_BITS:0]             sin_tab [exyz_pkg::SIN_ENTRIES];
  logic [exyz_pkg::ANGLE_WIDTH-1:0]    ang;
  logic [exyz_pkg::ANGLE_WIDTH-1:0]    ang_cos;
  exyz_pkg::fold_t                     fs;
  exyz_pkg::fold_t                     fc;
  logic [TW-1:0]                       mag_s;
  logic [TW-1:0]                       mag_c;
  logic signed [TW-1:0]                sin_new;
  logic signed [TW-1:0]                cos_new;

  // quarter-wave sine table, rounded to nearest at the trig fraction
  for (genvar k = 0; k < exyz_pkg::SIN_ENTRIES; k++) begin : g_tab
    localparam logic [63:0] Q30 = exyz_pkg::sin_q30(k);
    localparam logic [63:0] RND = (Q30 + (64'd1 << (29 - TRIG_FRAC_BITS)))
                                  >> (30 - TRIG_FRAC_BITS);
    assign sin_tab[k] = RND[TRIG_FRAC_BITS:0];
  end

  // sine and cosine of the angle being written
  always_comb begin
    ang     = exyz_pkg::norm_angle({1'b0, cfg_wdata});
    ang_cos = exyz_pkg::norm_angle({1'b0, ang} + 10'd90);
    fs      = exyz_pkg::fold_angle(ang);
    fc      = exyz_pkg::fold_angle(ang_cos);
    mag_s   = {1'b0, sin_tab[fs.idx]};
    mag_c   = {1'b0, sin_tab[fc.idx]};
    sin_new = fs.neg ? -mag_s : mag_s;
    cos_new = fc.neg ? -mag_c : mag_c;
  end

  // coefficient registers, one pair per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sin_v[i] <= '0;
        cos_v[i] <= ONE;
      end
    end else if (cfg_wen) begin
      case (cfg_index)
        exyz_pkg::REG_ANGLE_X: begin
          sin_v[0] <= sin_new;
          cos_v[0] <= cos_new;
        end
        exyz_pkg::REG_ANGLE_Y: begin
          sin_v[1] <= sin_new;
          cos_v[1] <= cos_new;
        end
        exyz_pkg::REG_ANGLE_Z: begin
          sin_v[2] <= sin_new;
          cos_v[2] <= cos_new;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/exyz_axis.sv =====
`timescale 1ns / 1ps

module exyz_axis #(
  parameter exyz_pkg::axis_t AXIS           = exyz_pkg::AXIS_X,
  parameter int              TRIG_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sin_v,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cos_v,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  exyz_pkg::vec_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output exyz_pkg::vec_t                    out_data
);

  localparam int IW = exyz_pkg::INT_WIDTH;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = IW + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (TRIG_FRAC_BITS - 1);

  logic                 st1_vld;
  logic                 st2_vld;
  logic                 ready1;
  logic                 ready2;
  logic signed [IW-1:0] u_in;
  logic signed [IW-1:0] v_in;
  logic signed [PW-1:0] uc;
  logic signed [PW-1:0] vs;
  logic signed [PW-1:0] us;
  logic signed [PW-1:0] vc;
  exyz_pkg::vec_t       st1_vec;
  exyz_pkg::vec_t       st2_vec;
  exyz_pkg::vec_t       vec_next;
  logic signed [SW-1:0] sum_u;
  logic signed [SW-1:0] sum_v;
  logic signed [IW-1:0] u_new;
  logic signed [IW-1:0] v_new;

  // a stage takes a beat when empty or when its content moves on
  assign ready2    = !st2_vld || out_ready;
  assign ready1    = !st1_vld || ready2;
  assign in_ready  = ready1;
  assign out_valid = st2_vld;
  assign out_data  = st2_vec;

  // pick the coordinate pair turned by this axis
  always_comb begin
    case (AXIS)
      exyz_pkg::AXIS_X: begin
        u_in = in_data.y;
        v_in = in_data.z;
      end
      exyz_pkg::AXIS_Y: begin
        u_in = in_data.z;
        v_in = in_data.x;
      end
      exyz_pkg::AXIS_Z: begin
        u_in = in_data.x;
        v_in = in_data.y;
      end
      default: begin
        u_in = in_data.x;
        v_in = in_data.y;
      end
    endcase
  end

  // combine products, round half up, drop the trig fraction
  always_comb begin
    sum_u = SW'(uc) - SW'(vs) + HALF;
    sum_v = SW'(us) + SW'(vc) + HALF;
    u_new = sum_u[TRIG_FRAC_BITS+IW-1:TRIG_FRAC_BITS];
    v_new = sum_v[TRIG_FRAC_BITS+IW-1:TRIG_FRAC_BITS];
    vec_next = st1_vec;
    case (AXIS)
      exyz_pkg::AXIS_X: begin
        vec_next.y = u_new;
        vec_next.z = v_new;
      end
      exyz_pkg::AXIS_Y: begin
        vec_next.z = u_new;
        vec_next.x = v_new;
      end
      exyz_pkg::AXIS_Z: begin
        vec_next.x = u_new;
        vec_next.y = v_new;
      end
      default: begin
        vec_next.x = u_new;
        vec_next.y = v_new;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld <= 1'b0;
      st2_vld <= 1'b0;
    end else begin
      if (ready1) begin
        st1_vld <= in_valid;
      end
      if (ready2) begin
        st2_vld <= st1_vld;
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      uc      <= u_in * cos_v;
      vs      <= v_in * sin_v;
      us      <= u_in * sin_v;
      vc      <= v_in * cos_v;
      st1_vec <= in_data;
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (ready2 && st1_vld) begin
      st2_vec <= vec_next;
    end
  end

`ifndef SYNTH
  // rounded coordinates must fit the working width
  a_u_fits: assert property (@(posedge clk) disable iff (rst)
    st1_vld |-> (&sum_u[SW-1:TRIG_FRAC_BITS+IW-1]) || !(|sum_u[SW-1:TRIG_FRAC_BITS+IW-1]))
    else $error("axis step u overflow");
  a_v_fits: assert property (@(posedge clk) disable iff (rst)
    st1_vld |-> (&sum_v[SW-1:TRIG_FRAC_BITS+IW-1]) || !(|sum_v[SW-1:TRIG_FRAC_BITS+IW-1]))
    else $error("axis step v overflow");
  // a product beat always moves into an empty sum stage
  a_advance: assert property (@(posedge clk) disable iff (rst)
    st1_vld && !st2_vld |=> st2_vld)
    else $error("axis pipe bubble not filled");
`endif

endmodule

// ===== hdl/exyz_sat.sv =====
`timescale 1ns / 1ps

module exyz_sat (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  exyz_pkg::vec_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output exyz_pkg::out_t out_data
);

  localparam int CW = exyz_pkg::COORD_WIDTH;
  localparam int IW = exyz_pkg::INT_WIDTH;

  logic           vld;
  exyz_pkg::out_t res;
  exyz_pkg::out_t res_next;

  // clamp a working-width value to the coordinate range
  function automatic logic signed [CW-1:0] clamp(input logic signed [IW-1:0] v);
    logic [IW-CW:0] hi_bits;
    hi_bits = v[IW-1:CW-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return v[CW-1:0];
    end else if (v[IW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = res;

  always_comb begin
    res_next.x_out    = clamp(in_data.x);
    res_next.y_out    = clamp(in_data.y);
    res_next.z_out    = clamp(in_data.z);
    res_next.last_out = in_data.last;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/euler_xyz_vertex_rotation.sv =====
`timescale 1ns / 1ps

// Rotates one Q16.16 vertex per clock (when out_ready does not stall it) about x,
// then y, then z by the whole-degree angles in registers 0, 1 and 2 (angles of 360
// and above wrap by 360). Sine and cosine come from a quarter-wave table with
// TRIG_FRAC_BITS fraction bits, looked up when a register is written, so a new angle
// applies to the very next vertex. Each axis turn is two stages (four multipliers,
// then a rounding add), and a final stage saturates to the coordinate range. The last
// flag rides along unchanged. Back-pressure stalls only as far as needed: empty stages
// keep filling while the output waits.
module euler_xyz_vertex_rotation #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [exyz_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [exyz_pkg::ANGLE_WIDTH-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  exyz_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output exyz_pkg::out_t                    out_data
);

  localparam int IW = exyz_pkg::INT_WIDTH;

  logic signed [TRIG_FRAC_BITS+1:0] sin_v [3];
  logic signed [TRIG_FRAC_BITS+1:0] cos_v [3];
  exyz_pkg::vec_t                   vin;
  exyz_pkg::vec_t                   vx;
  exyz_pkg::vec_t                   vy;
  exyz_pkg::vec_t                   vz;
  logic                             vx_valid;
  logic                             vx_ready;
  logic                             vy_valid;
  logic                             vy_ready;
  logic                             vz_valid;
  logic                             vz_ready;

  // widen the incoming vertex
  always_comb begin
    vin.x    = IW'(in_data.x_in);
    vin.y    = IW'(in_data.y_in);
    vin.z    = IW'(in_data.z_in);
    vin.last = in_data.last_in;
  end

  // angle registers and trig coefficients
  exyz_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .sin_v    (sin_v),
    .cos_v    (cos_v)
  );

  // rotation about x
  exyz_axis #(
    .AXIS          (exyz_pkg::AXIS_X),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .sin_v    (sin_v[0]),
    .cos_v    (cos_v[0]),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (vin),
    .out_valid(vx_valid),
    .out_ready(vx_ready),
    .out_data (vx)
  );

  // rotation about y
  exyz_axis #(
    .AXIS          (exyz_pkg::AXIS_Y),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .sin_v    (sin_v[1]),
    .cos_v    (cos_v[1]),
    .in_valid (vx_valid),
    .in_ready (vx_ready),
    .in_data  (vx),
    .out_valid(vy_valid),
    .out_ready(vy_ready),
    .out_data (vy)
  );

  // rotation about z
  exyz_axis #(
    .AXIS          (exyz_pkg::AXIS_Z),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_axis_z (
    .clk      (clk),
    .rst      (rst),
    .sin_v    (sin_v[2]),
    .cos_v    (cos_v[2]),
    .in_valid (vy_valid),
    .in_ready (vy_ready),
    .in_data  (vy),
    .out_valid(vz_valid),
    .out_ready(vz_ready),
    .out_data (vz)
  );

  // saturation and output register
  exyz_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vz_valid),
    .in_ready (vz_ready),
    .in_data  (vz),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== dv/euler_xyz_vertex_rotation_test.sv =====
`timescale 1ns / 1ps

module euler_xyz_vertex_rotation_test;

  localparam int TRIG_FRAC = 15;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  // pi scaled by 2^52
  localparam longint unsigned PI_SCALED = 64'h0032_43F6_A888_5A31;
  // index that maps to no register
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  exyz_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  exyz_pkg::out_t out_data;

  // shadow of the angle registers
  logic [8:0] angle_deg [0:2] = '{9'd0, 9'd0, 9'd0};
  exyz_pkg::in_t pending_vertices[$];
  exyz_pkg::out_t rotated_expect[$];
  bit in_idle = 1'b0;
  bit out_idle = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  euler_xyz_vertex_rotation u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sin(k deg) for k in 0..90 as unsigned Q30, odd power series to x^17
  function automatic longint unsigned sine_series_q30(int unsigned k);
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned div;
    ang = ((longint'(k) * PI_SCALED) / 180 + (64'd1 << 21)) >> 22;
    sq = (ang * ang + (64'd1 << 29)) >> 30;
    term = ang;
    acc = ang;
    for (int n = 1; n <= 8; n++) begin
      div = longint'(2 * n) * longint'(2 * n + 1);
      term = (term * sq + (64'd1 << 29)) >> 30;
      term = (term + div / 2) / div;
      if (n % 2 == 1) begin
        acc = (term > acc) ? 64'd0 : acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // quarter-wave value rounded to the trig fraction width
  function automatic longint quarter_sine(int unsigned k);
    longint unsigned q;
    q = sine_series_q30(k);
    return longint'((q + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
  endfunction

  function automatic longint sine_of_deg(logic [8:0] a);
    int unsigned d;
    d = a;
    if (d <= 90) return quarter_sine(d);
    if (d <= 180) return quarter_sine(180 - d);
    if (d <= 270) return -quarter_sine(d - 180);
    return -quarter_sine(360 - d);
  endfunction

  function automatic logic [8:0] wrap_deg(logic [8:0] a);
    return (a >= 9'd360) ? a - 9'd360 : a;
  endfunction

  // (p*ta + q*tb) / 2^F, ties toward plus infinity
  function automatic longint turn_mac(longint p, longint ta, longint q, longint tb);
    longint acc;
    acc = p * ta + q * tb + (64'sd1 <<< (TRIG_FRAC - 1));
    return acc >>> TRIG_FRAC;
  endfunction

  function automatic logic signed [31:0] clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[31:0];
  endfunction

  // rotate about x, then y, then z with the current angles
  function automatic exyz_pkg::out_t rotate_vertex(exyz_pkg::in_t v);
    longint s, c, x1, y1, z1, x2, z2, x3, y3;
    logic [8:0] a;
    exyz_pkg::out_t r;
    x1 = longint'($signed(v.x_in));
    a = wrap_deg(angle_deg[0]);
    s = sine_of_deg(a);
    c = sine_of_deg(wrap_deg(a + 9'd90));
    y1 = turn_mac(longint'($signed(v.y_in)), c, longint'($signed(v.z_in)), -s);
    z1 = turn_mac(longint'($signed(v.y_in)), s, longint'($signed(v.z_in)), c);
    a = wrap_deg(angle_deg[1]);
    s = sine_of_deg(a);
    c = sine_of_deg(wrap_deg(a + 9'd90));
    x2 = turn_mac(x1, c, z1, s);
    z2 = turn_mac(z1, c, x1, -s);
    a = wrap_deg(angle_deg[2]);
    s = sine_of_deg(a);
    c = sine_of_deg(wrap_deg(a + 9'd90));
    x3 = turn_mac(x2, c, y1, -s);
    y3 = turn_mac(x2, s, y1, c);
    r.x_out = clamp_coord(x3);
    r.y_out = clamp_coord(y3);
    r.z_out = clamp_coord(z2);
    r.last_out = v.last_in;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [8:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd90;
      2: return 9'd180;
      3: return 9'd270;
      4: return 9'd359;
      5: return 9'd360;
      6: return 9'd511;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // input driver: one beat at a time from the pending queue, gap drawn per beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        rotated_expect.push_back(rotate_vertex(in_data));
      end
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_vertices.size() != 0) begin
        in_data <= pending_vertices.pop_front();
        in_valid <= 1'b1;
        in_gap <= in_idle ? $urandom_range(0, 11) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor: compare each beat with the oldest expected vertex
  always @(posedge clk) begin : monitor
    exyz_pkg::out_t want;
    int stall;
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rotated_expect.size() == 0) begin
          $error("unexpected result beat: x_out %0d y_out %0d z_out %0d",
                 out_data.x_out, out_data.y_out, out_data.z_out);
          fail_count++;
        end else begin
          want = rotated_expect.pop_front();
          if (out_data.x_out !== want.x_out) begin
            $error("x_out: expected %0d, got %0d", want.x_out, out_data.x_out);
            fail_count++;
          end
          if (out_data.y_out !== want.y_out) begin
            $error("y_out: expected %0d, got %0d", want.y_out, out_data.y_out);
            fail_count++;
          end
          if (out_data.z_out !== want.z_out) begin
            $error("z_out: expected %0d, got %0d", want.z_out, out_data.z_out);
            fail_count++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
            fail_count++;
          end
        end
        stall = out_idle ? $urandom_range(0, 11) : 0;
        out_ready <= (stall == 0);
        out_hold <= stall;
      end else if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_ready <= (out_hold == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("euler_xyz_vertex_rotation test failed");
    $finish;
  end

  // register write while the pipe is empty, shadow follows
  task automatic write_angle(logic [1:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      exyz_pkg::REG_ANGLE_X: angle_deg[0] = val;
      exyz_pkg::REG_ANGLE_Y: angle_deg[1] = val;
      exyz_pkg::REG_ANGLE_Z: angle_deg[2] = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_pacing(int mode);
    in_idle = mode[0];
    out_idle = mode[1];
  endtask

  // corner vertices: zero, both extremes, mixed signs, small values
  task automatic queue_corners();
    pending_vertices.push_back('{32'sd0, 32'sd0, 32'sd0, 1'b0});
    pending_vertices.push_back('{COORD_MAX, COORD_MAX, COORD_MAX, 1'b1});
    pending_vertices.push_back('{COORD_MIN, COORD_MIN, COORD_MIN, 1'b0});
    pending_vertices.push_back('{COORD_MAX, COORD_MIN, COORD_MAX, 1'b1});
    pending_vertices.push_back('{32'sd1, -32'sd1, 32'sd65536, 1'b0});
  endtask

  // wait for every vertex to come back, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (pending_vertices.size() != 0 || in_valid || rotated_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int count;
    exyz_pkg::in_t v;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset angles, then quarter turns, odd angles, wrap-around and the unused index
    set_pacing(0);
    queue_corners();
    drain();
    write_angle(exyz_pkg::REG_ANGLE_X, 9'd90);
    write_angle(exyz_pkg::REG_ANGLE_Y, 9'd180);
    write_angle(exyz_pkg::REG_ANGLE_Z, 9'd270);
    set_pacing(3);
    queue_corners();
    drain();
    write_angle(exyz_pkg::REG_ANGLE_X, 9'd45);
    write_angle(exyz_pkg::REG_ANGLE_Y, 9'd135);
    write_angle(exyz_pkg::REG_ANGLE_Z, 9'd315);
    set_pacing(1);
    queue_corners();
    drain();
    write_angle(exyz_pkg::REG_ANGLE_X, 9'd359);
    write_angle(exyz_pkg::REG_ANGLE_Y, 9'd360);
    write_angle(exyz_pkg::REG_ANGLE_Z, 9'd511);
    write_angle(REG_UNUSED, 9'd77);
    set_pacing(2);
    queue_corners();
    drain();
    write_angle(exyz_pkg::REG_ANGLE_X, 9'd1);
    write_angle(exyz_pkg::REG_ANGLE_Y, 9'd89);
    write_angle(exyz_pkg::REG_ANGLE_Z, 9'd450);
    set_pacing(0);
    queue_corners();
    drain();

    // random angle sets, each with a stream of random vertices
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_angle(exyz_pkg::REG_ANGLE_X, pick_angle());
      write_angle(exyz_pkg::REG_ANGLE_Y, pick_angle());
      write_angle(exyz_pkg::REG_ANGLE_Z, pick_angle());
      if ($urandom_range(0, 2) == 0) begin
        write_angle(REG_UNUSED, 9'($urandom_range(0, 511)));
      end
      set_pacing(p % 4);
      count = $urandom_range(120, 185);
      for (int i = 0; i < count; i++) begin
        v.x_in = pick_coord();
        v.y_in = pick_coord();
        v.z_in = pick_coord();
        v.last_in = ($urandom_range(0, 7) == 0);
        pending_vertices.push_back(v);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("euler_xyz_vertex_rotation test passed");
    end else begin
      $display("euler_xyz_vertex_rotation test failed");
    end
    $finish;
  end

endmodule
